/* sv/rapqf_pkg.sv */
`default_nettype none
package rapqf_pkg;

	// widths of the item fields
	localparam int IDX_W = 11;
	localparam int VAL_W = 32;
	// node position while walking: climbing may step past the 11-bit range
	localparam int POS_W = IDX_W + 1;

	localparam int ENTRIES_DEF = 1024;
	localparam logic [IDX_W-1:0] SIZE_RST = IDX_W'(1024);

	// operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// lowest set bit of a node position
	function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] v);
		return v & (~v + POS_W'(1));
	endfunction

endpackage
`default_nettype wire

/* sv/range_add_point_query_fenwick_top.sv */
`default_nettype none
// range add / point query store over a fenwick tree of 32-bit words
//
// input channel (in_valid / in_stall): one word per item. operation OP_ADD adds
// amount to positions first_index..last_index; OP_QUERY returns the value at
// first_index. output channel (out_valid / out_stall): one word per query,
// point_value and out_of_range; adds give no word.
// config: cfg_wr_en / cfg_wr_data write tree_size; write it only while idle.
//
// timing: the tree sits in one simple dual-port ram with a registered read. the
// walk issues one node read per cycle, but for a bubble between the two climbs
// of an add; the write-back of a node overlaps the read of the next one. an add
// climbs from first_index, then from last_index + 1 with amount negated; a query
// descends from first_index. one item is worked on at a time.
// a finished query result waits in the output register; while out_stall holds
// it, the block still takes the next item and only a second result waits.
// reset: after arst_n releases, a clearing pass writes zero to all ENTRIES
// words, one per cycle; in_stall stays high until done.
module range_add_point_query_fenwick_top #(
	parameter int ENTRIES = rapqf_pkg::ENTRIES_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_wr_en,
	input  wire  [rapqf_pkg::IDX_W-1:0]            cfg_wr_data,
	// input channel
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire                                    operation,
	input  wire  [rapqf_pkg::IDX_W-1:0]            first_index,
	input  wire  [rapqf_pkg::IDX_W-1:0]            last_index,
	input  wire  signed [rapqf_pkg::VAL_W-1:0]     amount,
	// output channel
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic signed [rapqf_pkg::VAL_W-1:0]     point_value,
	output logic                                   out_of_range
);
	import rapqf_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	// tree storage, node at position p lives at address p-1
	logic [VAL_W-1:0] mem [ENTRIES];

	logic [IDX_W-1:0] tree_size_q;
	logic [AW-1:0]    clr_cnt_q;

	// walk control
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] n_q;
	logic [IDX_W-1:0] last_q;
	logic [VAL_W-1:0] delta_q;
	logic             desc_q;   // descending path (query)
	logic             path1_q;  // still on the climb from first_index
	logic             oor_q;
	logic [VAL_W-1:0] acc_q;

	// read-data stage
	logic             vld_s2;
	logic [AW-1:0]    addr_s2;
	logic [VAL_W-1:0] delta_s2;
	logic             desc_s2;
	logic [VAL_W-1:0] rd_data_s2;

	// result register
	logic             out_valid_q;
	logic [VAL_W-1:0] point_value_q;
	logic             out_of_range_q;

	logic             in_acc;
	logic [POS_W-1:0] n_cur;
	logic [POS_W-1:0] first_ext;
	logic             q_oor;
	logic             add_live;
	logic             issue_ok;
	logic             switch_path;
	logic             walk_done;
	logic [POS_W-1:0] pos_m1;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// size register saturated to the store depth
	assign n_cur     = (32'(tree_size_q) > 32'(ENTRIES)) ? POS_W'(ENTRIES) : POS_W'(tree_size_q);
	assign first_ext = POS_W'(first_index);
	assign q_oor     = first_ext > n_cur;
	assign add_live  = (first_index != '0) && !q_oor;

	// one node read per cycle while the current path still has nodes
	assign issue_ok    = (state_q == ST_WALK) && (pos_q != '0) && (desc_q || pos_q <= n_q);
	assign switch_path = (state_q == ST_WALK) && !issue_ok && !desc_q && path1_q;
	assign walk_done   = (state_q == ST_WALK) && !issue_ok && !switch_path;

	assign pos_m1  = pos_q - POS_W'(1);
	assign rd_en   = issue_ok;
	assign rd_addr = AW'(pos_m1);

	// write port: clearing pass, else read-modify-write of the climb
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = '0;
		end else begin
			wr_en   = vld_s2 && !desc_s2;
			wr_addr = addr_s2;
			wr_data = rd_data_s2 + delta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			tree_size_q <= SIZE_RST;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tree_size_q <= cfg_wr_data;
			end
			vld_s2 <= rd_en;
			// result word loaded from emit, else dropped once taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && (operation == OP_QUERY || add_live)) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= desc_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					// last accumulate landed in the previous cycle
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		addr_s2  <= rd_addr;
		delta_s2 <= delta_q;
		desc_s2  <= desc_q;

		if (in_acc) begin
			n_q     <= n_cur;
			last_q  <= last_index;
			delta_q <= amount;
			acc_q   <= '0;
			if (operation == OP_QUERY) begin
				desc_q  <= 1'b1;
				path1_q <= 1'b0;
				oor_q   <= q_oor;
				pos_q   <= q_oor ? '0 : first_ext;
			end else begin
				desc_q  <= 1'b0;
				path1_q <= 1'b1;
				oor_q   <= 1'b0;
				pos_q   <= first_ext;
			end
		end else begin
			if (issue_ok) begin
				pos_q <= desc_q ? (pos_q - low_bit(pos_q)) : (pos_q + low_bit(pos_q));
			end else if (switch_path) begin
				// bubble cycle here keeps the last write ahead of the next read
				pos_q   <= POS_W'(last_q) + POS_W'(1);
				delta_q <= -delta_q;
				path1_q <= 1'b0;
			end
			if (vld_s2 && desc_s2) begin
				acc_q <= acc_q + rd_data_s2;
			end
		end

		if (state_q == ST_EMIT && out_free) begin
			point_value_q  <= acc_q;
			out_of_range_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_value  = point_value_q;
	assign out_of_range = out_of_range_q;

	// ram never sees a read and write of one word in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write of the same tree word in one cycle");

	// a result word is only raised from the emit state
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result word raised outside emit");

	// the clearing pass runs with no walk in flight
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!vld_s2 && !rd_en))
		else $error("tree access during clearing pass");

	// once a walk finishes, no tree read is in flight in the next cycle
	a_walk_drains: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> !vld_s2)
		else $error("read still in flight after walk end");

endmodule
`default_nettype wire
